@@ rtl/core/dprx_pkg.sv @@
// Shared types and constants for the debug packet receiver.
package dprx_pkg;

  // Request selector on the input side
  typedef enum logic [1:0] {
    FN_LINK     = 2'd0,
    FN_ACK_WAIT = 2'd1,
    FN_READ     = 2'd2,
    FN_SPARE    = 2'd3
  } func_e;

  // Result kinds as seen on the output port
  typedef enum logic [2:0] {
    EV_TX      = 3'd0,
    EV_READY   = 3'd1,
    EV_BREAK   = 3'd2,
    EV_DISCARD = 3'd3,
    EV_RESEND  = 3'd4,
    EV_READ    = 3'd5
  } event_kind_e;

  // Work handed from the front end to the back end
  typedef enum logic [2:0] {
    CMD_TX      = 3'd0,
    CMD_BREAK   = 3'd1,
    CMD_DISCARD = 3'd2,
    CMD_RESEND  = 3'd3,
    CMD_READ    = 3'd4,
    CMD_ACK     = 3'd5,
    CMD_ACK_SEQ = 3'd6
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [7:0]  b0;   // char to send, read data or first sequence id char
    logic [7:0]  b1;   // second sequence id char
  } cmd_t;

  localparam int unsigned CmdW = $bits(cmd_t);

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_ETX    = 8'h03;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_COLON  = 8'h3a;

  localparam int unsigned QueueDepth = 4;

endpackage

@@ rtl/core/debug_packet_receiver_core.sv @@
// Receiver for '$'-framed debug packets with hex checksum; one request per cycle
// is taken unless the input stalls. The front end classifies each request and
// writes payload bytes into its store in the cycle it is accepted; results go
// through a four-entry command queue to the back end, which shows one result per
// cycle on a registered output while the output is not stalled. A good packet
// end yields two results, or four with a sequence id, and holds the back end
// until all are shown, so the input stalls only when the queue fills. Payload
// reads take their data from the store's registered read port, loaded at accept.
module debug_packet_receiver_core #(
  parameter int unsigned MAX_PAYLOAD = 4096
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        func_i,
  input  logic [7:0]                        rx_byte_i,
  input  logic [$clog2(MAX_PAYLOAD)-1:0]    read_index_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [2:0]                        event_kind_o,
  output logic [7:0]                        event_byte_o,
  output logic [$clog2(MAX_PAYLOAD+1)-1:0]  packet_length_o,
  output logic [1:0]                        payload_start_o,
  output logic                              last_of_run_o
);

  localparam int unsigned AddrW = $clog2(MAX_PAYLOAD);
  localparam int unsigned CntW  = $clog2(MAX_PAYLOAD + 1);
  localparam int unsigned DataW = CntW + dprx_pkg::CmdW;

  logic             push, full, pop, empty;
  logic [DataW-1:0] push_data, head;

  dprx_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD),
    .AddrW      (AddrW),
    .CntW       (CntW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .rx_byte_i   (rx_byte_i),
    .read_index_i(read_index_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  dprx_fifo #(
    .DataW(DataW)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_data),
    .full_o (full),
    .pop_i  (pop),
    .data_o (head),
    .empty_o(empty)
  );

  dprx_back #(
    .CntW(CntW)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .empty_i        (empty),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .event_kind_o   (event_kind_o),
    .event_byte_o   (event_byte_o),
    .packet_length_o(packet_length_o),
    .payload_start_o(payload_start_o),
    .last_of_run_o  (last_of_run_o)
  );

endmodule

@@ rtl/core/dprx_front.sv @@
// Front end: framing state machine, payload store and command issue.
module dprx_front #(
  parameter int unsigned MAX_PAYLOAD = 4096,
  parameter int unsigned AddrW = 12,
  parameter int unsigned CntW = 13
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  func_i,
  input  logic [7:0]                  rx_byte_i,
  input  logic [AddrW-1:0]            read_index_i,
  output logic                        push_o,
  output logic [CntW+dprx_pkg::CmdW-1:0] push_data_o,
  input  logic                        full_i
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_TERM, PH_CRC1, PH_CRC2, PH_ACK
  } phase_e;

  localparam logic [CntW-1:0] MaxCount = CntW'(MAX_PAYLOAD);

  // bit 4 flags a non-hex character
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b0, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b0, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b0, 4'(c - 8'h37)};
    return r;
  endfunction

  phase_e            phase_q, phase_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [7:0]        sum_q, sum_d;
  logic [8:0]        rsum_q, rsum_d;
  logic [7:0]        seq_q [3];
  logic [7:0]        store [MAX_PAYLOAD];
  logic [7:0]        rd_q;
  logic              hit_q, hit_d;

  logic              cmd_valid_q;
  dprx_pkg::cmd_t    cmd_q, cmd_d;
  logic [CntW-1:0]   len_q, len_d;
  logic              has_cmd;
  logic              we, re, accept;
  logic [4:0]        h;
  logic [8:0]        rsum_fin;
  dprx_pkg::cmd_t    push_cmd;

  assign push_o     = cmd_valid_q && !full_i;
  assign in_stall_o = cmd_valid_q && full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign h          = hex_val(rx_byte_i);
  assign rsum_fin   = h[4] ? 9'h100 : (rsum_q | {5'b0, h[3:0]});

  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    sum_d   = sum_q;
    rsum_d  = rsum_q;
    has_cmd = 1'b0;
    cmd_d   = '{kind: dprx_pkg::CMD_TX, b0: 8'h00, b1: 8'h00};
    len_d   = '0;
    hit_d   = 1'b0;
    we      = 1'b0;
    re      = 1'b0;
    if (accept) begin
      case (func_i)
        dprx_pkg::FN_LINK: begin
          unique case (phase_q)
            PH_IDLE: begin
              if (rx_byte_i == dprx_pkg::CH_DOLLAR) begin
                phase_d = PH_TERM;
                count_d = '0;
                sum_d   = '0;
                rsum_d  = '0;
              end else if (rx_byte_i == dprx_pkg::CH_ETX) begin
                has_cmd    = 1'b1;
                cmd_d.kind = dprx_pkg::CMD_BREAK;
              end
            end
            PH_TERM: begin
              if (rx_byte_i == dprx_pkg::CH_HASH) begin
                phase_d = PH_CRC1;
              end else if (count_q >= MaxCount) begin
                has_cmd  = 1'b1;
                cmd_d.b0 = dprx_pkg::CH_MINUS;
                phase_d  = PH_IDLE;
              end else begin
                we      = 1'b1;
                count_d = count_q + 1'b1;
                sum_d   = sum_q + rx_byte_i;
              end
            end
            PH_CRC1: begin
              rsum_d  = h[4] ? 9'h100 : {1'b0, h[3:0], 4'h0};
              phase_d = PH_CRC2;
            end
            PH_CRC2: begin
              rsum_d  = rsum_fin;
              phase_d = PH_IDLE;
              has_cmd = 1'b1;
              if (rsum_fin != {1'b0, sum_q}) begin
                cmd_d.b0 = dprx_pkg::CH_MINUS;
              end else if (count_q >= CntW'(3) && seq_q[2] == dprx_pkg::CH_COLON) begin
                cmd_d.kind = dprx_pkg::CMD_ACK_SEQ;
                cmd_d.b0   = seq_q[0];
                cmd_d.b1   = seq_q[1];
                len_d      = count_q - CntW'(3);
              end else begin
                cmd_d.kind = dprx_pkg::CMD_ACK;
                len_d      = count_q;
              end
            end
            PH_ACK: begin
              if (rx_byte_i == dprx_pkg::CH_PLUS) begin
                has_cmd    = 1'b1;
                cmd_d.kind = dprx_pkg::CMD_DISCARD;
                phase_d    = PH_IDLE;
              end else if (rx_byte_i == dprx_pkg::CH_MINUS) begin
                has_cmd    = 1'b1;
                cmd_d.kind = dprx_pkg::CMD_RESEND;
              end else if (rx_byte_i == dprx_pkg::CH_DOLLAR) begin
                phase_d = PH_TERM;
                count_d = '0;
                sum_d   = '0;
                rsum_d  = '0;
              end
            end
            default: phase_d = PH_IDLE;
          endcase
        end
        dprx_pkg::FN_ACK_WAIT: phase_d = PH_ACK;
        dprx_pkg::FN_READ: begin
          re         = 1'b1;
          has_cmd    = 1'b1;
          cmd_d.kind = dprx_pkg::CMD_READ;
          hit_d      = CntW'(read_index_i) < count_q;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      count_q     <= '0;
      sum_q       <= '0;
      rsum_q      <= '0;
      cmd_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
      sum_q   <= sum_d;
      rsum_q  <= rsum_d;
      if (accept) cmd_valid_q <= has_cmd;
      else if (push_o) cmd_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && has_cmd) begin
      cmd_q <= cmd_d;
      len_q <= len_d;
      hit_q <= hit_d;
    end
    for (int j = 0; j < 3; j++) begin
      if (we && count_q == CntW'(j)) seq_q[j] <= rx_byte_i;
    end
  end

  // payload store, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) store[count_q[AddrW-1:0]] <= rx_byte_i;
    if (re) rd_q <= store[read_index_i];
  end

  always_comb begin
    push_cmd = cmd_q;
    if (cmd_q.kind == dprx_pkg::CMD_READ) push_cmd.b0 = hit_q ? rd_q : 8'h00;
  end

  assign push_data_o = {len_q, push_cmd};

endmodule

@@ rtl/core/dprx_fifo.sv @@
// Short command queue between front and back end.
module dprx_fifo #(
  parameter int unsigned DataW = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [DataW-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [DataW-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned Depth = dprx_pkg::QueueDepth;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  logic [DataW-1:0] slot_q [Depth];
  logic [PtrW-1:0]  head_q, tail_q;
  logic [CntW-1:0]  cnt_q;

  assign full_o  = cnt_q == CntW'(Depth);
  assign empty_o = cnt_q == '0;
  assign data_o  = slot_q[head_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) tail_q <= (tail_q == PtrW'(Depth - 1)) ? '0 : tail_q + 1'b1;
      if (pop_i) head_q <= (head_q == PtrW'(Depth - 1)) ? '0 : head_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[tail_q] <= data_i;
  end

endmodule

@@ rtl/core/dprx_back.sv @@
// Back end: expands queued commands into result beats behind an output register.
module dprx_back #(
  parameter int unsigned CntW = 13
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [CntW+dprx_pkg::CmdW-1:0] head_i,
  input  logic                           empty_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [2:0]                     event_kind_o,
  output logic [7:0]                     event_byte_o,
  output logic [CntW-1:0]                packet_length_o,
  output logic [1:0]                     payload_start_o,
  output logic                           last_of_run_o
);

  dprx_pkg::cmd_t  cmd;
  logic [CntW-1:0] len;
  logic [1:0]      beat_q;
  logic            load, take, last;

  dprx_pkg::event_kind_e kind_d;
  logic [7:0]      byte_d;
  logic [CntW-1:0] len_d;
  logic [1:0]      start_d;

  logic            valid_q;
  logic [2:0]      kind_q;
  logic [7:0]      byte_q;
  logic [CntW-1:0] len_q;
  logic [1:0]      start_q;
  logic            last_q;

  assign cmd  = head_i[dprx_pkg::CmdW-1:0];
  assign len  = head_i[CntW+dprx_pkg::CmdW-1:dprx_pkg::CmdW];
  assign load = !valid_q || !out_stall_i;
  assign take = load && !empty_i;
  assign pop_o = take && last;

  always_comb begin
    kind_d  = dprx_pkg::EV_TX;
    byte_d  = 8'h00;
    len_d   = '0;
    start_d = 2'd0;
    last    = 1'b1;
    unique case (cmd.kind)
      dprx_pkg::CMD_TX:      byte_d = cmd.b0;
      dprx_pkg::CMD_BREAK:   kind_d = dprx_pkg::EV_BREAK;
      dprx_pkg::CMD_DISCARD: kind_d = dprx_pkg::EV_DISCARD;
      dprx_pkg::CMD_RESEND:  kind_d = dprx_pkg::EV_RESEND;
      dprx_pkg::CMD_READ: begin
        kind_d = dprx_pkg::EV_READ;
        byte_d = cmd.b0;
      end
      dprx_pkg::CMD_ACK: begin
        if (beat_q == 2'd0) begin
          byte_d = dprx_pkg::CH_PLUS;
          last   = 1'b0;
        end else begin
          kind_d = dprx_pkg::EV_READY;
          len_d  = len;
        end
      end
      dprx_pkg::CMD_ACK_SEQ: begin
        // '+', two id chars, then packet ready
        last = 1'b0;
        case (beat_q)
          2'd0: byte_d = dprx_pkg::CH_PLUS;
          2'd1: byte_d = cmd.b0;
          2'd2: byte_d = cmd.b1;
          default: begin
            kind_d  = dprx_pkg::EV_READY;
            len_d   = len;
            start_d = 2'd3;
            last    = 1'b1;
          end
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      beat_q  <= '0;
    end else begin
      if (load) valid_q <= !empty_i;
      if (take) beat_q <= last ? 2'd0 : beat_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      kind_q  <= kind_d;
      byte_q  <= byte_d;
      len_q   <= len_d;
      start_q <= start_d;
      last_q  <= last;
    end
  end

  assign out_valid_o     = valid_q;
  assign event_kind_o    = kind_q;
  assign event_byte_o    = byte_q;
  assign packet_length_o = len_q;
  assign payload_start_o = start_q;
  assign last_of_run_o   = last_q;

endmodule

@@ tb/tb_debug_packet_receiver_core.sv @@
// Self-checking testbench for the debug packet receiver core.
`timescale 1ns / 100ps

module tb_debug_packet_receiver_core;

  localparam int unsigned MaxPayload = 4096;
  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned TargetRequests = 280;

  // checksum variants for generated packets
  localparam int SUM_GOOD   = 0;
  localparam int SUM_WRONG  = 1;
  localparam int SUM_BAD_HI = 2;
  localparam int SUM_BAD_LO = 3;

  typedef enum logic [2:0] {
    RX_IDLE, RX_BODY, RX_SUM_HI, RX_SUM_LO, RX_ACK_WAIT
  } rx_phase_e;

  typedef struct {
    logic [1:0]  func;
    logic [7:0]  ch;
    logic [11:0] idx;
    bit          hold;  // wait for all results before presenting
  } req_t;

  typedef struct packed {
    dprx_pkg::event_kind_e kind;
    logic [7:0]            data;
    logic [12:0]           len;
    logic [1:0]            start;
    logic                  last;
  } evt_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  func_i;
  logic [7:0]  rx_byte_i;
  logic [11:0] read_index_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [2:0]  event_kind_o;
  logic [7:0]  event_byte_o;
  logic [12:0] packet_length_o;
  logic [1:0]  payload_start_o;
  logic        last_of_run_o;

  debug_packet_receiver_core #(
    .MAX_PAYLOAD(MaxPayload)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .func_i          (func_i),
    .rx_byte_i       (rx_byte_i),
    .read_index_i    (read_index_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .event_kind_o    (event_kind_o),
    .event_byte_o    (event_byte_o),
    .packet_length_o (packet_length_o),
    .payload_start_o (payload_start_o),
    .last_of_run_o   (last_of_run_o)
  );

  req_t link_requests[$];
  evt_t pending_events[$];
  bit   hold_next;
  int   total_reqs;
  int   req_count;
  int   err_count;
  int   quiet_cycles;
  logic req_taken;

  // predictor state
  rx_phase_e   rx_phase;
  logic [12:0] body_len;
  logic [7:0]  body_sum;
  logic [8:0]  wire_sum;
  logic [7:0]  body_mem [0:MaxPayload-1];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [4:0] hex_value(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b0, 4'(c - 8'h30)};
    if (c >= 8'h61 && c <= 8'h66) return {1'b0, 4'(c - 8'h61 + 8'd10)};
    if (c >= 8'h41 && c <= 8'h46) return {1'b0, 4'(c - 8'h41 + 8'd10)};
    return 5'h10;
  endfunction

  function automatic evt_t make_evt(dprx_pkg::event_kind_e k, logic [7:0] b,
                                    logic [12:0] n, logic [1:0] s);
    evt_t e;
    e.kind  = k;
    e.data  = b;
    e.len   = n;
    e.start = s;
    e.last  = 1'b0;
    return e;
  endfunction

  function automatic void open_packet();
    rx_phase = RX_BODY;
    body_len = '0;
    body_sum = '0;
    wire_sum = '0;
  endfunction

  // works out the results of one accepted request and queues them
  function automatic void compute_events(logic [1:0] f, logic [7:0] c, logic [11:0] i);
    evt_t       res[$];
    logic [4:0] h;
    case (f)
      dprx_pkg::FN_LINK: begin
        case (rx_phase)
          RX_IDLE: begin
            if (c == dprx_pkg::CH_DOLLAR) open_packet();
            else if (c == dprx_pkg::CH_ETX)
              res.push_back(make_evt(dprx_pkg::EV_BREAK, 8'h00, '0, '0));
          end
          RX_BODY: begin
            if (c == dprx_pkg::CH_HASH) begin
              rx_phase = RX_SUM_HI;
            end else if (body_len >= MaxPayload) begin
              res.push_back(make_evt(dprx_pkg::EV_TX, dprx_pkg::CH_MINUS, '0, '0));
              rx_phase = RX_IDLE;
            end else begin
              body_mem[body_len] = c;
              body_len = body_len + 13'd1;
              body_sum = body_sum + c;
            end
          end
          RX_SUM_HI: begin
            h = hex_value(c);
            wire_sum = h[4] ? 9'h100 : {1'b0, h[3:0], 4'h0};
            rx_phase = RX_SUM_LO;
          end
          RX_SUM_LO: begin
            h = hex_value(c);
            wire_sum = h[4] ? 9'h100 : (wire_sum | {5'b0, h[3:0]});
            rx_phase = RX_IDLE;
            if (wire_sum != {1'b0, body_sum}) begin
              res.push_back(make_evt(dprx_pkg::EV_TX, dprx_pkg::CH_MINUS, '0, '0));
            end else begin
              res.push_back(make_evt(dprx_pkg::EV_TX, dprx_pkg::CH_PLUS, '0, '0));
              // sequence id: "xx:" at the head of the payload
              if (body_len >= 13'd3 && body_mem[2] == dprx_pkg::CH_COLON) begin
                res.push_back(make_evt(dprx_pkg::EV_TX, body_mem[0], '0, '0));
                res.push_back(make_evt(dprx_pkg::EV_TX, body_mem[1], '0, '0));
                res.push_back(make_evt(dprx_pkg::EV_READY, 8'h00, body_len - 13'd3,
                                       2'd3));
              end else begin
                res.push_back(make_evt(dprx_pkg::EV_READY, 8'h00, body_len, 2'd0));
              end
            end
          end
          RX_ACK_WAIT: begin
            if (c == dprx_pkg::CH_PLUS) begin
              res.push_back(make_evt(dprx_pkg::EV_DISCARD, 8'h00, '0, '0));
              rx_phase = RX_IDLE;
            end else if (c == dprx_pkg::CH_MINUS) begin
              res.push_back(make_evt(dprx_pkg::EV_RESEND, 8'h00, '0, '0));
            end else if (c == dprx_pkg::CH_DOLLAR) begin
              open_packet();
            end
          end
          default: rx_phase = RX_IDLE;
        endcase
      end
      dprx_pkg::FN_ACK_WAIT: rx_phase = RX_ACK_WAIT;
      dprx_pkg::FN_READ: begin
        res.push_back(make_evt(dprx_pkg::EV_READ,
                               ({1'b0, i} < body_len) ? body_mem[i] : 8'h00, '0, '0));
      end
      default: ;
    endcase
    if (res.size() > 0) res[res.size()-1].last = 1'b1;
    foreach (res[k]) pending_events.push_back(res[k]);
  endfunction

  // stimulus helpers
  task automatic queue_req(logic [1:0] f, logic [7:0] c, logic [11:0] i);
    req_t r;
    r.func = f;
    r.ch   = c;
    r.idx  = i;
    r.hold = hold_next;
    hold_next = 1'b0;
    link_requests.push_back(r);
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    logic [4:0] h;
    do begin
      c = 8'($urandom_range(255));
      h = hex_value(c);
    end while (!h[4]);
    return c;
  endfunction

  function automatic logic [7:0] body_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (c == dprx_pkg::CH_HASH);
    return c;
  endfunction

  task automatic queue_packet(input logic [7:0] pl[$], input int sum_mode);
    logic [7:0] s;
    logic [7:0] hi;
    logic [7:0] lo;
    s = '0;
    foreach (pl[k]) s = s + pl[k];
    if (sum_mode == SUM_WRONG) s = s + 8'($urandom_range(1, 255));
    hi = (sum_mode == SUM_BAD_HI) ? non_hex_char() : hex_char(s[7:4]);
    lo = (sum_mode == SUM_BAD_LO) ? non_hex_char() : hex_char(s[3:0]);
    queue_req(dprx_pkg::FN_LINK, dprx_pkg::CH_DOLLAR, '0);
    foreach (pl[k]) queue_req(dprx_pkg::FN_LINK, pl[k], '0);
    queue_req(dprx_pkg::FN_LINK, dprx_pkg::CH_HASH, '0);
    queue_req(dprx_pkg::FN_LINK, hi, '0);
    queue_req(dprx_pkg::FN_LINK, lo, '0);
  endtask

  task automatic build_stimulus();
    logic [7:0] pl[$];
    int         n;
    int         r;
    int         m;

    // directed part
    queue_req(dprx_pkg::FN_LINK, dprx_pkg::CH_ETX, '0);
    queue_req(dprx_pkg::FN_SPARE, 8'hff, 12'hfff);
    queue_req(dprx_pkg::FN_ACK_WAIT, '0, '0);
    queue_req(dprx_pkg::FN_LINK, dprx_pkg::CH_MINUS, '0);
    queue_req(dprx_pkg::FN_LINK, dprx_pkg::CH_PLUS, '0);
    pl = {8'hff, 8'h00, dprx_pkg::CH_COLON};
    queue_packet(pl, SUM_GOOD);
    queue_req(dprx_pkg::FN_READ, '0, 12'h000);
    queue_req(dprx_pkg::FN_READ, '0, 12'hfff);
    queue_req(dprx_pkg::FN_ACK_WAIT, '0, '0);
    pl = {};
    queue_packet(pl, SUM_GOOD);
    queue_packet(pl, SUM_BAD_HI);
    pl = {dprx_pkg::CH_COLON, dprx_pkg::CH_COLON};
    queue_packet(pl, SUM_GOOD);

    hold_next = 1'b1;
    while (link_requests.size() < TargetRequests) begin
      if ($urandom_range(99) < 4) hold_next = 1'b1;
      r = $urandom_range(99);
      if (r < 55) begin
        m = $urandom_range(99);
        n = (m < 80) ? $urandom_range(8) : (m < 95) ? $urandom_range(9, 40)
                                                    : $urandom_range(41, 200);
        pl = {};
        repeat (n) pl.push_back(body_byte());
        if (n >= 3 && $urandom_range(2) == 0) pl[2] = dprx_pkg::CH_COLON;
        if ($urandom_range(4) == 0) queue_req(dprx_pkg::FN_ACK_WAIT, '0, '0);
        m = $urandom_range(99);
        queue_packet(pl, (m < 70) ? SUM_GOOD : (m < 80) ? SUM_WRONG :
                         (m < 90) ? SUM_BAD_HI : SUM_BAD_LO);
      end else if (r < 65) begin
        queue_req(dprx_pkg::FN_ACK_WAIT, '0, '0);
        repeat ($urandom_range(1, 4)) begin
          m = $urandom_range(2);
          queue_req(dprx_pkg::FN_LINK,
                    (m == 0) ? dprx_pkg::CH_PLUS : (m == 1) ? dprx_pkg::CH_MINUS
                                                 : 8'($urandom_range(255)), '0);
        end
      end else if (r < 77) begin
        repeat ($urandom_range(1, 3))
          queue_req(dprx_pkg::FN_READ, 8'($urandom_range(255)),
                    $urandom_range(1) ? 12'($urandom_range(15))
                                      : 12'($urandom_range(4095)));
      end else if (r < 85) begin
        // packet broken off part way
        queue_req(dprx_pkg::FN_LINK, dprx_pkg::CH_DOLLAR, '0);
        repeat ($urandom_range(5)) queue_req(dprx_pkg::FN_LINK, body_byte(), '0);
        if ($urandom_range(1)) queue_req(dprx_pkg::FN_LINK, dprx_pkg::CH_HASH, '0);
        queue_req($urandom_range(1) ? dprx_pkg::FN_ACK_WAIT : dprx_pkg::FN_SPARE,
                  8'($urandom_range(255)), 12'($urandom_range(4095)));
      end else if (r < 93) begin
        repeat ($urandom_range(1, 4))
          queue_req(dprx_pkg::FN_LINK,
                    $urandom_range(3) == 0 ? dprx_pkg::CH_ETX : 8'($urandom_range(255)),
                    12'($urandom_range(4095)));
      end else begin
        queue_req(dprx_pkg::FN_SPARE, 8'($urandom_range(255)),
                  12'($urandom_range(4095)));
      end
    end
  endtask

  // request driver
  always @(negedge clk_i) begin
    int   mode;
    int   send_idle;
    int   recv_idle;
    req_t nxt;
    if (rst_ni) begin
      mode = (total_reqs > 0) ? (req_count * 3) / total_reqs : 2;
      send_idle = (mode == 0) ? 16 : (mode == 1) ? 80 : 0;
      recv_idle = (mode == 0) ? 80 : (mode == 1) ? 16 : 0;
      if (!in_valid_i || req_taken) begin
        if (link_requests.size() > 0 && !(link_requests[0].hold && pending_events.size() != 0)
            && $urandom_range(99) >= send_idle) begin
          nxt = link_requests.pop_front();
          in_valid_i   <= 1'b1;
          func_i       <= nxt.func;
          rx_byte_i    <= nxt.ch;
          read_index_i <= nxt.idx;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_idle);
    end
  end

  // monitor, predictor update and watchdog
  always @(posedge clk_i) begin
    evt_t e;
    bit   moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (out_valid_o && !out_stall_i) begin
        moved = 1'b1;
        if (pending_events.size() == 0) begin
          if (err_count < 10)
            $display("unexpected result: kind %0d byte %h len %0d start %0d last %0b",
                     event_kind_o, event_byte_o, packet_length_o, payload_start_o,
                     last_of_run_o);
          err_count++;
        end else begin
          e = pending_events.pop_front();
          if (event_kind_o != e.kind || event_byte_o != e.data ||
              packet_length_o != e.len || payload_start_o != e.start ||
              last_of_run_o != e.last) begin
            if (err_count < 10)
              $display("exp/act: kind %0d/%0d byte %h/%h len %0d/%0d start %0d/%0d last %0b/%0b",
                       e.kind, event_kind_o, e.data, event_byte_o, e.len,
                       packet_length_o, e.start, payload_start_o, e.last, last_of_run_o);
            err_count++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        moved = 1'b1;
        compute_events(func_i, rx_byte_i, read_index_i);
        req_count++;
      end
      req_taken <= in_valid_i && !in_stall_o;
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("watchdog expired");
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    func_i       = dprx_pkg::FN_LINK;
    rx_byte_i    = '0;
    read_index_i = '0;
    out_stall_i  = 1'b0;
    req_taken    = 1'b0;
    hold_next    = 1'b0;
    req_count    = 0;
    err_count    = 0;
    quiet_cycles = 0;
    rx_phase     = RX_IDLE;
    body_len     = '0;
    body_sum     = '0;
    wire_sum     = '0;
    total_reqs   = 0;
    build_stimulus();
    total_reqs = link_requests.size();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    wait (req_count == total_reqs);
    wait (pending_events.size() == 0);
    repeat (20) @(posedge clk_i);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/dprx_pkg.sv
rtl/core/dprx_front.sv
rtl/core/dprx_fifo.sv
rtl/core/dprx_back.sv
rtl/core/debug_packet_receiver_core.sv
tb/tb_debug_packet_receiver_core.sv
